>>> rtl/core/sact_pkg.sv
// Shared constants, row types and LFSR helpers for the set-associative tag lookup.
// No dependencies.
package sact_pkg;

    localparam int SETS       = 64;
    localparam int WAYS       = 4;
    localparam int LINE_BYTES = 32;
    localparam int ADDR_BITS  = 32;

    localparam int OFF_BITS  = $clog2(LINE_BYTES);
    localparam int IDX_BITS  = $clog2(SETS);
    localparam int TAG_W     = ADDR_BITS - OFF_BITS - IDX_BITS;
    localparam int WAY_BITS  = $clog2(WAYS);
    localparam int AGE_BITS  = WAY_BITS;
    localparam int CNT_BITS  = 32;
    localparam int SEED_BITS = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [SEED_BITS-1:0] SEED_AT_RESET = 16'd44257;
    localparam logic [SEED_BITS-1:0] LFSR_TAPS     = 16'hB400;
    localparam logic [AGE_BITS-1:0]  AGE_TOP       = AGE_BITS'(WAYS - 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POLICY = 1'b0,
        CFG_SEED   = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        POLICY_LRU    = 1'b0,
        POLICY_RANDOM = 1'b1
    } policy_t;

    typedef logic [WAYS-1:0][AGE_BITS-1:0] age_row_t;
    typedef logic [WAYS-1:0][TAG_W-1:0]    tag_row_t;

    typedef struct packed {
        tag_row_t tag;
        age_row_t age;
    } row_t;

    function automatic logic [SEED_BITS-1:0] seed_value(input logic [SEED_BITS-1:0] s);
        return (s == '0) ? SEED_AT_RESET : s;
    endfunction

    function automatic logic [SEED_BITS-1:0] lfsr_next(input logic [SEED_BITS-1:0] s);
        logic [SEED_BITS-1:0] r;
        r = s >> 1;
        if (s[0])
        begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

    function automatic age_row_t age_reset();
        age_row_t r;
        for (int w = 0; w < WAYS; w++)
        begin
            r[w] = AGE_BITS'(w);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/set_assoc_cache_tag_lookup.sv
// Set-associative cache tag lookup with LRU or LFSR replacement and hit/miss totals.
// Depends on sact_pkg for geometry, row types and LFSR helpers.
// One item is accepted every cycle while the result side takes items; its result is loaded
// into the output register after the registered read of the tag/age row memory (one row per
// set) taken at the accepting edge, followed by a single compare-and-update pass. When the
// result side stalls, one item waits in the lookup stage and one in the output register
// before the input is held off. A row written at the same edge it is read is forwarded into
// the read register. Reset needs no clearing pass: way valid bits and per-set age-initialised
// flags live in flip-flops. Configuration writes are held off while an item sits in the
// lookup stage.
module set_assoc_cache_tag_lookup
    import sact_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ADDR_BITS-1:0]    address,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    hit,
    output logic [WAY_BITS-1:0]     way,
    output logic [CNT_BITS-1:0]     hit_total,
    output logic [CNT_BITS-1:0]     miss_total,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SEED_BITS-1:0]    cfg_data
);

    row_t                         row_mem [SETS];

    logic                         s1_valid_reg;
    logic [ADDR_BITS-1:0]         s1_addr_reg;
    row_t                         s1_row_reg;
    logic                         out_valid_reg;
    logic                         hit_reg;
    logic [WAY_BITS-1:0]          way_reg;
    logic [CNT_BITS-1:0]          hits_reg;
    logic [CNT_BITS-1:0]          misses_reg;
    logic [SEED_BITS-1:0]         lfsr_reg;
    policy_t                      policy_reg;
    logic [SETS-1:0][WAYS-1:0]    valid_reg;
    logic [SETS-1:0]              row_init_reg;

    logic                         in_acc;
    logic                         out_free;
    logic                         s1_adv;
    logic [IDX_BITS-1:0]          in_set;
    logic [IDX_BITS-1:0]          s1_set;
    logic [TAG_W-1:0]             s1_tag;
    age_row_t                     cur_age;
    logic [WAYS-1:0]              cur_valid;
    logic                         s1_hit;
    logic [WAY_BITS-1:0]          hit_way;
    logic [WAY_BITS-1:0]          s1_way;
    logic [SEED_BITS-1:0]         lfsr_step;
    row_t                         row_next;
    logic [WAYS-1:0]              valid_next;
    logic [WAYS-1:0]              age_top_vec;
    logic [CNT_BITS-1:0]          hits_next;
    logic [CNT_BITS-1:0]          misses_next;

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_adv    = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = !s1_valid_reg;

    assign in_set = address[OFF_BITS +: IDX_BITS];
    assign s1_set = s1_addr_reg[OFF_BITS +: IDX_BITS];
    assign s1_tag = s1_addr_reg[ADDR_BITS-1 -: TAG_W];

    assign out_valid  = out_valid_reg;
    assign hit        = hit_reg;
    assign way        = way_reg;
    assign hit_total  = hits_reg;
    assign miss_total = misses_reg;

    always_comb
    begin
        cur_age   = row_init_reg[s1_set] ? s1_row_reg.age : age_reset();
        cur_valid = valid_reg[s1_set];
        lfsr_step = lfsr_next(lfsr_reg);
        s1_hit    = 1'b0;
        hit_way   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (cur_valid[w] && (s1_row_reg.tag[w] == s1_tag))
            begin
                s1_hit  = 1'b1;
                hit_way = WAY_BITS'(w);
            end
        end

        row_next.tag = s1_row_reg.tag;
        row_next.age = cur_age;
        valid_next   = cur_valid;
        s1_way       = hit_way;

        if (s1_hit)
        begin
            if (policy_reg == POLICY_LRU)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (cur_age[w] > cur_age[hit_way])
                    begin
                        row_next.age[w] = cur_age[w] - AGE_BITS'(1);
                    end
                end
                row_next.age[hit_way] = AGE_TOP;
            end
        end
        else if (policy_reg == POLICY_LRU)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                if (cur_age[w] == '0)
                begin
                    s1_way          = WAY_BITS'(w);
                    valid_next[w]   = 1'b1;
                    row_next.tag[w] = s1_tag;
                    row_next.age[w] = AGE_TOP;
                end
                else
                begin
                    row_next.age[w] = cur_age[w] - AGE_BITS'(1);
                end
            end
        end
        else
        begin
            s1_way               = WAY_BITS'(lfsr_step % WAYS);
            valid_next[s1_way]   = 1'b1;
            row_next.tag[s1_way] = s1_tag;
        end

        for (int w = 0; w < WAYS; w++)
        begin
            age_top_vec[w] = (row_next.age[w] == AGE_TOP);
        end

        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (s1_hit)
        begin
            if (hits_reg != '1)
            begin
                hits_next = hits_reg + CNT_BITS'(1);
            end
        end
        else if (misses_reg != '1)
        begin
            misses_next = misses_reg + CNT_BITS'(1);
        end
    end

    // Row memory: read-before-write, with the row being written forwarded to the reader.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            row_mem[s1_set] <= row_next;
        end
        if (in_acc)
        begin
            if (s1_adv && (s1_set == in_set))
            begin
                s1_row_reg <= row_next;
            end
            else
            begin
                s1_row_reg <= row_mem[in_set];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_addr_reg <= address;
        end
        if (s1_adv)
        begin
            hit_reg <= s1_hit;
            way_reg <= s1_way;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            lfsr_reg      <= SEED_AT_RESET;
            policy_reg    <= POLICY_LRU;
            valid_reg     <= '0;
            row_init_reg  <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (s1_adv)
            begin
                hits_reg             <= hits_next;
                misses_reg           <= misses_next;
                valid_reg[s1_set]    <= valid_next;
                row_init_reg[s1_set] <= 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_POLICY:
                    begin
                        policy_reg <= policy_t'(cfg_data[0]);
                    end
                    CFG_SEED:
                    begin
                        lfsr_reg <= seed_value(cfg_data);
                    end
                endcase
            end
            else if (s1_adv && !s1_hit && (policy_reg == POLICY_RANDOM))
            begin
                lfsr_reg <= lfsr_step;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_hits_advance: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_hit && (hits_reg != '1) |=> hits_reg == $past(hits_reg) + CNT_BITS'(1))
        else $error("hit total did not advance on a hit");

    a_age_perm: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |-> $onehot(age_top_vec))
        else $error("written age row has no single most recent way");

    a_fill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> valid_reg[$past(s1_set)][$past(s1_way)])
        else $error("reported way not valid after the item");

    a_lru_victim: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && !s1_hit && (policy_reg == POLICY_LRU) |-> cur_age[s1_way] == '0)
        else $error("LRU miss filled a way that was not the oldest");
`endif

endmodule

>>> dv/lookup_checker.sv
`timescale 1ns / 1ps
// Checker for set_assoc_cache_tag_lookup: keeps its own copy of the valid, tag and age state,
// predicts hit, way and totals for every accepted address, compares each result item in order.
// Depends on sact_pkg for geometry, field widths and the register and policy codes.
module lookup_checker
    import sact_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  logic [ADDR_BITS-1:0]    address,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  logic                    hit,
    input  logic [WAY_BITS-1:0]     way,
    input  logic [CNT_BITS-1:0]     hit_total,
    input  logic [CNT_BITS-1:0]     miss_total,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SEED_BITS-1:0]    cfg_data,
    output int unsigned             mismatch_count,
    output int unsigned             pending,
    output int unsigned             results_checked,
    output int unsigned             hits_checked
);

    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way;
        logic [CNT_BITS-1:0] hits;
        logic [CNT_BITS-1:0] misses;
    } lookup_result_t;

    localparam logic [CNT_BITS-1:0] COUNT_MAX    = '1;
    localparam int unsigned         REPORT_LIMIT = 10;

    logic                 line_ok   [SETS][WAYS];
    logic [TAG_W-1:0]     line_tags [SETS][WAYS];
    logic [AGE_BITS-1:0]  line_age  [SETS][WAYS];
    logic [CNT_BITS-1:0]  hits_model;
    logic [CNT_BITS-1:0]  misses_model;
    logic [SEED_BITS-1:0] victim_state;
    policy_t              policy;

    lookup_result_t expected_q [$];
    int unsigned    bad;
    int unsigned    seen;
    int unsigned    seen_hits;

    function automatic logic [SEED_BITS-1:0] seed_load(input logic [SEED_BITS-1:0] s);
        return (s == '0) ? SEED_AT_RESET : s;
    endfunction

    function automatic logic [SEED_BITS-1:0] lfsr_advance(input logic [SEED_BITS-1:0] s);
        logic [SEED_BITS-1:0] n;
        n = {1'b0, s[SEED_BITS-1:1]};
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

    function automatic void clear_lookup_state();
        for (int s = 0; s < SETS; s++)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                line_ok[s][w]   = 1'b0;
                line_tags[s][w] = '0;
                line_age[s][w]  = AGE_BITS'(w);
            end
        end
        hits_model   = '0;
        misses_model = '0;
        policy       = POLICY_LRU;
        victim_state = seed_load(SEED_AT_RESET);
    endfunction

    function automatic lookup_result_t predict_lookup(input logic [ADDR_BITS-1:0] a);
        lookup_result_t      r;
        logic [TAG_W-1:0]    tag;
        logic [AGE_BITS-1:0] old_age;
        int                  set_i;
        int                  found;
        int                  victim;
        tag    = a[ADDR_BITS-1 -: TAG_W];
        set_i  = int'(a[OFF_BITS +: IDX_BITS]);
        found  = -1;
        victim = 0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (found < 0 && line_ok[set_i][w] && line_tags[set_i][w] == tag)
            begin
                found = w;
            end
        end
        if (found >= 0)
        begin
            victim = found;
            if (hits_model != COUNT_MAX)
            begin
                hits_model = hits_model + 1'b1;
            end
            if (policy == POLICY_LRU)
            begin
                old_age = line_age[set_i][found];
                for (int w = 0; w < WAYS; w++)
                begin
                    if (line_age[set_i][w] > old_age)
                    begin
                        line_age[set_i][w] = line_age[set_i][w] - 1'b1;
                    end
                end
                line_age[set_i][found] = AGE_TOP;
            end
        end
        else
        begin
            if (misses_model != COUNT_MAX)
            begin
                misses_model = misses_model + 1'b1;
            end
            if (policy == POLICY_LRU)
            begin
                for (int w = 0; w < WAYS; w++)
                begin
                    if (line_age[set_i][w] == '0)
                    begin
                        victim             = w;
                        line_ok[set_i][w]  = 1'b1;
                        line_tags[set_i][w] = tag;
                        line_age[set_i][w] = AGE_TOP;
                    end
                    else
                    begin
                        line_age[set_i][w] = line_age[set_i][w] - 1'b1;
                    end
                end
            end
            else
            begin
                victim_state = lfsr_advance(victim_state);
                victim       = int'(victim_state % WAYS);
                line_ok[set_i][victim]   = 1'b1;
                line_tags[set_i][victim] = tag;
            end
        end
        r.hit    = (found >= 0);
        r.way    = WAY_BITS'(victim);
        r.hits   = hits_model;
        r.misses = misses_model;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t want;
        if (!rst_n)
        begin
            clear_lookup_state();
            expected_q.delete();
            bad       = 0;
            seen      = 0;
            seen_hits = 0;
            mismatch_count  <= 0;
            pending         <= 0;
            results_checked <= 0;
            hits_checked    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_POLICY: policy = policy_t'(cfg_data[0]);
                    CFG_SEED:   victim_state = seed_load(cfg_data);
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(predict_lookup(address));
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    bad++;
                    if (bad <= REPORT_LIMIT)
                    begin
                        $display("%0t: result item with none outstanding: hit %0b way %0d",
                                 $realtime, hit, way);
                    end
                end
                else
                begin
                    want = expected_q.pop_front();
                    seen++;
                    if (want.hit)
                    begin
                        seen_hits++;
                    end
                    if (want.hit !== hit || want.way !== way ||
                        want.hits !== hit_total || want.misses !== miss_total)
                    begin
                        bad++;
                        if (bad <= REPORT_LIMIT)
                        begin
                            $display("%0t: item %0d exp hit %0b way %0d hits %0d misses %0d",
                                     $realtime, seen, want.hit, want.way, want.hits,
                                     want.misses);
                            $display("%0t: item %0d got hit %0b way %0d hits %0d misses %0d",
                                     $realtime, seen, hit, way, hit_total, miss_total);
                        end
                    end
                end
            end
            mismatch_count  <= bad;
            pending         <= expected_q.size();
            results_checked <= seen;
            hits_checked    <= seen_hits;
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Top of the tag lookup testbench: clock, reset, address and register stimulus, receiver stalls.
// Depends on sact_pkg, set_assoc_cache_tag_lookup and lookup_checker.
module testbench;
    import sact_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int          HOT_TAGS    = 6;
    localparam int          HOT_SETS    = 4;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [ADDR_BITS-1:0]    address   = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    hit;
    logic [WAY_BITS-1:0]     way;
    logic [CNT_BITS-1:0]     hit_total;
    logic [CNT_BITS-1:0]     miss_total;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_POLICY;
    logic [SEED_BITS-1:0]    cfg_data  = '0;

    int unsigned mismatch_count;
    int unsigned pending;
    int unsigned results_checked;
    int unsigned hits_checked;
    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;
    bit          hold_request = 1'b0;

    logic [TAG_W-1:0]     hot_tags [HOT_TAGS];
    logic [IDX_BITS-1:0]  hot_sets [HOT_SETS];
    logic [ADDR_BITS-1:0] last_addr = '0;

    set_assoc_cache_tag_lookup dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .address    (address),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hit        (hit),
        .way        (way),
        .hit_total  (hit_total),
        .miss_total (miss_total),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    lookup_checker lookup_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .address         (address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hit             (hit),
        .way             (way),
        .hit_total       (hit_total),
        .miss_total      (miss_total),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending         (pending),
        .results_checked (results_checked),
        .hits_checked    (hits_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int unsigned mode;
        int unsigned tick;
        int unsigned held;
        mode = 0;
        tick = 0;
        held = 0;
        forever
        begin
            @(posedge clk);
            if (tick == 0)
            begin
                mode = $urandom_range(0, 3);
                tick = $urandom_range(16, 96);
            end
            tick--;
            if (hold_request && held < HOLD_CYCLES)
            begin
                out_ready <= 1'b0;
                held++;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= tick[1];
                endcase
            end
        end
    end

    function automatic logic [ADDR_BITS-1:0] lookup_addr(input logic [TAG_W-1:0] tag,
                                                         input logic [IDX_BITS-1:0] set_i);
        return {tag, set_i, OFF_BITS'($urandom)};
    endfunction

    function automatic void shuffle_working_set();
        for (int i = 0; i < HOT_TAGS; i++)
        begin
            hot_tags[i] = TAG_W'($urandom);
        end
        for (int i = 0; i < HOT_SETS; i++)
        begin
            hot_sets[i] = IDX_BITS'($urandom);
        end
    endfunction

    function automatic logic [ADDR_BITS-1:0] next_address();
        logic [ADDR_BITS-1:0] a;
        int unsigned          pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            a = lookup_addr(hot_tags[$urandom_range(0, HOT_TAGS - 1)],
                            hot_sets[$urandom_range(0, HOT_SETS - 1)]);
        end
        else if (pick < 75)
        begin
            a = lookup_addr(hot_tags[$urandom_range(0, HOT_TAGS - 1)],
                            last_addr[OFF_BITS +: IDX_BITS]);
        end
        else
        begin
            a = $urandom;
        end
        last_addr = a;
        return a;
    endfunction

    task automatic send_lookup(input logic [ADDR_BITS-1:0] a);
        in_valid <= 1'b1;
        address  <= a;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [SEED_BITS-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned gap;
        shuffle_working_set();
        for (int unsigned i = 0; i < count; i++)
        begin
            send_lookup(next_address());
            if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 24);
                gap        = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // LRU: extremes, same line, eviction of the oldest way, promotion on hit
        write_register(CFG_POLICY, SEED_BITS'(POLICY_LRU));
        write_register(CFG_SEED, 16'd1);
        send_lookup(32'h0000_0000);
        send_lookup(32'hFFFF_FFFF);
        send_lookup(32'h0000_001F);
        for (int t = 1; t <= 4; t++)
        begin
            send_lookup(ADDR_BITS'(t) << (OFF_BITS + IDX_BITS));
        end
        send_lookup(32'h0000_0000);
        send_lookup(32'h0000_1000);
        send_lookup(32'h0000_2800);
        send_lookup(32'hFFFF_FFE0);
        send_lookup(32'h0000_07E0);
        drain();

        // random victims from a zero seed, then a repeat of an early tag
        write_register(CFG_POLICY, SEED_BITS'(POLICY_RANDOM));
        write_register(CFG_SEED, 16'd0);
        for (int t = 0; t < 6; t++)
        begin
            send_lookup((ADDR_BITS'(t) << (OFF_BITS + IDX_BITS)) | 32'h0000_0020);
        end
        send_lookup(32'h0000_0020);
        run_random(300);
        drain();

        write_register(CFG_SEED, 16'hFFFF);
        run_random(300);
        drain();

        // back to LRU over ages left from random mode; the receiver holds off in one long stall at its start
        write_register(CFG_POLICY, SEED_BITS'(POLICY_LRU));
        hold_request = 1'b1;
        run_random(400);
        drain();

        write_register(CFG_POLICY, SEED_BITS'(POLICY_RANDOM));
        write_register(CFG_SEED, SEED_BITS'($urandom_range(1, 65535)));
        run_random(250);
        drain();

        write_register(CFG_POLICY, SEED_BITS'(POLICY_LRU));
        run_random(250);
        drain();

        repeat (8) @(posedge clk);
        $display("Checked %0d lookups: %0d hits, %0d misses", results_checked, hits_checked,
                 results_checked - hits_checked);
        $display("Phases: LRU and random victims, seeds 0, 1, 65535 and random, long output stall");
        if (mismatch_count == 0 && pending == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
